FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the charge sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: rtl/bbcs_pkg.sv
// Shared types and constants of the backup battery charge sequencer.
package bbcs_pkg;

    // Operation codes of a request
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_FORCE   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Phase codes as reported on the result
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_MEAS  = 2'd1;
    localparam logic [1:0] PH_CHRG  = 2'd2;
    localparam logic [1:0] PH_RELAX = 2'd3;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_PERIOD    = 3'd1;
    localparam logic [2:0] REG_SETTLE    = 3'd2;
    localparam logic [2:0] REG_CHARGE    = 3'd3;
    localparam logic [2:0] REG_REST      = 3'd4;

    localparam int ADDR_W = 5;

    // Register reset values
    localparam logic [13:0] THRESHOLD_RST = 14'd2850;
    localparam logic [30:0] PERIOD_RST    = 31'(1 * 24 * 3600 * 1000);
    localparam logic [15:0] SETTLE_RST    = 16'd100;
    localparam logic [30:0] CHARGE_RST    = 31'(2 * 3600 * 1000);
    localparam logic [30:0] REST_RST      = 31'(5 * 60 * 1000);

    typedef struct packed {
        logic [13:0] threshold_mv;
        logic [30:0] period_ms;
        logic [15:0] settle_ms;
        logic [30:0] charge_ms;
        logic [30:0] rest_ms;
    } cfg_t;

    typedef struct packed {
        logic        charge_enable;
        logic        divider_enable;
        logic [13:0] battery_mv;
        logic [1:0]  phase;
    } result_t;

endpackage

FILE: rtl/bbcs_core.sv
// Input register and phase sequencing logic of the charge sequencer.
module bbcs_core (
    input  logic             clk,
    input  logic             rst_n,
    input  bbcs_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       operation,
    input  logic [31:0]      now_ms,
    input  logic             adc_ready,
    input  logic [13:0]      sample_mv,
    input  logic             res_space,
    output logic             res_push,
    output bbcs_pkg::result_t res_data
);
    import bbcs_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = PH_IDLE,
        ST_MEAS  = PH_MEAS,
        ST_CHRG  = PH_CHRG,
        ST_RELAX = PH_RELAX
    } state_t;

    // Input stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [1:0]  s1_op_reg;
    logic [31:0] s1_now_reg;
    logic        s1_ready_reg;
    logic [13:0] s1_sample_reg;
    logic        in_take;
    logic        go;

    // Sequencer state
    state_t      state_reg, state_next;
    logic [31:0] anchor_reg, anchor_next;
    logic [31:0] cmark_reg, cmark_next;
    logic [31:0] smark_reg, smark_next;
    logic        due_reg, due_next;
    logic        after_reg, after_next;
    logic [13:0] latched_reg, latched_next;
    logic        charge_reg, charge_next;
    logic        divider_reg, divider_next;

    logic [31:0] mark_sel;
    logic [31:0] limit_sel;
    logic [31:0] elapsed;
    logic        reached;

    assign go       = s1_valid_reg && res_space;
    assign in_stall = s1_valid_reg && !res_space;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next = in_take || (s1_valid_reg && !go);

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg     <= operation;
            s1_now_reg    <= now_ms;
            s1_ready_reg  <= adc_ready;
            s1_sample_reg <= sample_mv;
        end
    end

    // One shared wrapping difference, mark and limit picked by phase
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                mark_sel  = anchor_reg;
                limit_sel = {1'b0, cfg.period_ms};
            end
            ST_MEAS:
            begin
                mark_sel  = smark_reg;
                limit_sel = {16'd0, cfg.settle_ms};
            end
            ST_CHRG:
            begin
                mark_sel  = cmark_reg;
                limit_sel = {1'b0, cfg.charge_ms};
            end
            ST_RELAX:
            begin
                mark_sel  = cmark_reg;
                limit_sel = {1'b0, cfg.rest_ms};
            end
            default:
            begin
                mark_sel  = cmark_reg;
                limit_sel = {1'b0, cfg.rest_ms};
            end
        endcase
    end

    assign elapsed = s1_now_reg - mark_sel;
    assign reached = elapsed >= limit_sel;

    always_comb
    begin
        state_next   = state_reg;
        anchor_next  = anchor_reg;
        cmark_next   = cmark_reg;
        smark_next   = smark_reg;
        due_next     = due_reg;
        after_next   = after_reg;
        latched_next = latched_reg;
        charge_next  = charge_reg;
        divider_next = divider_reg;

        case (s1_op_reg)
            OP_TICK:
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        if ((due_reg || reached) && s1_ready_reg)
                        begin
                            anchor_next  = s1_now_reg;
                            due_next     = 1'b0;
                            after_next   = 1'b0;
                            divider_next = 1'b1;
                            smark_next   = s1_now_reg;
                            state_next   = ST_MEAS;
                        end
                    end
                    ST_MEAS:
                    begin
                        if (reached)
                        begin
                            latched_next = s1_sample_reg;
                            divider_next = 1'b0;
                            // a confirming reading never restarts charging
                            if ((s1_sample_reg < cfg.threshold_mv) && !after_reg)
                            begin
                                charge_next = 1'b1;
                                cmark_next  = s1_now_reg;
                                state_next  = ST_CHRG;
                            end
                            else
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    ST_CHRG:
                    begin
                        if (reached)
                        begin
                            charge_next = 1'b0;
                            cmark_next  = s1_now_reg;
                            state_next  = ST_RELAX;
                        end
                    end
                    ST_RELAX:
                    begin
                        if (reached)
                        begin
                            after_next = 1'b1;
                            if (s1_ready_reg)
                            begin
                                divider_next = 1'b1;
                                smark_next   = s1_now_reg;
                                state_next   = ST_MEAS;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            OP_FORCE:
            begin
                charge_next = 1'b0;
                due_next    = 1'b1;
                state_next  = ST_IDLE;
            end
            OP_RESTART:
            begin
                charge_next = 1'b1;
                cmark_next  = s1_now_reg;
                state_next  = ST_CHRG;
            end
            default:
            begin
                // unused code: state held, result still reported
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            state_reg    <= ST_IDLE;
            anchor_reg   <= '0;
            cmark_reg    <= '0;
            smark_reg    <= '0;
            due_reg      <= 1'b1;
            after_reg    <= 1'b0;
            latched_reg  <= '0;
            charge_reg   <= 1'b0;
            divider_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (go)
            begin
                state_reg   <= state_next;
                anchor_reg  <= anchor_next;
                cmark_reg   <= cmark_next;
                smark_reg   <= smark_next;
                due_reg     <= due_next;
                after_reg   <= after_next;
                latched_reg <= latched_next;
                charge_reg  <= charge_next;
                divider_reg <= divider_next;
            end
        end
    end

    assign res_push                = go;
    assign res_data.charge_enable  = charge_next;
    assign res_data.divider_enable = divider_next;
    assign res_data.battery_mv     = latched_next;
    assign res_data.phase          = state_next;

endmodule

FILE: rtl/bbcs_outbuf.sv
// Two-entry result buffer that decouples the sequencer from the output stall.
module bbcs_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bbcs_pkg::result_t push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_stall,
    output bbcs_pkg::result_t head
);
    import bbcs_pkg::*;

    result_t     mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign out_valid = cnt_reg != 2'd0;
    assign pop       = out_valid && !out_stall;
    assign space     = (cnt_reg != 2'd2) || pop;
    assign head      = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: rtl/backup_battery_charge_sequencer_unit.sv
// Top level of the backup battery charge sequencer: register port and datapath.
//
// Backup battery charge sequencer. Each request carries an operation (periodic
// tick, forced measurement, or charge restart), the current millisecond time,
// the converter-ready flag and the converted battery voltage; each request
// gives exactly one result showing the switch states, last latched voltage and
// phase (idle, measuring, charging, relax) after that request. All time checks
// are wrapping 32-bit differences against stored marks. One request per clock
// is sustained while the buffer has room: a request is held in the input
// register, where the phase logic runs one shared subtract and compare and
// updates all state, and the result goes into a two-entry output buffer;
// out_valid rises once that result is written into the buffer. in_stall rises
// only when the input register holds a request and both buffer entries are
// full with no result leaving. Registers live on an APB-style port at byte
// addresses 0x00 threshold_mv, 0x04 period_ms, 0x08 settle_ms, 0x0C charge_ms,
// 0x10 rest_ms; pready is always high and writes to other addresses are
// dropped. Change registers only while no request is in flight.
`include "assert_macros.svh"

module backup_battery_charge_sequencer_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    // register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bbcs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // request channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                operation,
    input  logic [31:0]               now_ms,
    input  logic                      adc_ready,
    input  logic [13:0]               sample_mv,
    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      charge_enable,
    output logic                      divider_enable,
    output logic [13:0]               battery_mv,
    output logic [1:0]                phase
);
    import bbcs_pkg::*;

    cfg_t        cfg_reg;
    logic        cfg_wr;
    logic [2:0]  reg_idx;

    result_t     res_data;
    result_t     head;
    logic        res_push;
    logic        res_space;

    // Register port: word index from paddr, low two bits ignored
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_mv <= THRESHOLD_RST;
            cfg_reg.period_ms    <= PERIOD_RST;
            cfg_reg.settle_ms    <= SETTLE_RST;
            cfg_reg.charge_ms    <= CHARGE_RST;
            cfg_reg.rest_ms      <= REST_RST;
        end
        else if (cfg_wr)
        begin
            // bits above each register's width are dropped
            unique case (reg_idx)
                REG_THRESHOLD: cfg_reg.threshold_mv <= pwdata[13:0];
                REG_PERIOD:    cfg_reg.period_ms    <= pwdata[30:0];
                REG_SETTLE:    cfg_reg.settle_ms    <= pwdata[15:0];
                REG_CHARGE:    cfg_reg.charge_ms    <= pwdata[30:0];
                REG_REST:      cfg_reg.rest_ms      <= pwdata[30:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESHOLD: prdata = {18'd0, cfg_reg.threshold_mv};
            REG_PERIOD:    prdata = {1'b0, cfg_reg.period_ms};
            REG_SETTLE:    prdata = {16'd0, cfg_reg.settle_ms};
            REG_CHARGE:    prdata = {1'b0, cfg_reg.charge_ms};
            REG_REST:      prdata = {1'b0, cfg_reg.rest_ms};
            default:       prdata = 32'd0;
        endcase
    end

    // Input register plus phase sequencing
    bbcs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .now_ms    (now_ms),
        .adc_ready (adc_ready),
        .sample_mv (sample_mv),
        .res_space (res_space),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // Result buffer toward the consumer
    bbcs_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .space     (res_space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign charge_enable  = head.charge_enable;
    assign divider_enable = head.divider_enable;
    assign battery_mv     = head.battery_mv;
    assign phase          = head.phase;

    // Charger switch is on exactly in the charging phase
    `ASSERT_IMPLY(a_charge_phase, clk, rst_n, out_valid,
                  charge_enable == (phase == PH_CHRG))
    // Measuring always runs with the divider on
    `ASSERT_IMPLY(a_meas_divider, clk, rst_n, out_valid && (phase == PH_MEAS),
                  divider_enable)
    // With the result buffer empty there is always room for a request
    `ASSERT_NEVER(a_stall_empty, clk, rst_n, !out_valid && in_stall)

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the backup battery charge sequencer unit.
`timescale 1ns / 1ps

module tb;
    import bbcs_pkg::*;

    // Reserved operation code: the block must ignore it but still answer.
    localparam logic [1:0] OP_IGNORED = 2'd3;

    // Runaway guard, far above the slowest legal run.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int NUM_PHASES = 6;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] now;
        logic        rdy;
        logic [13:0] mv;
    } request_t;

    // ------------------------------------------------------------------
    // Clock and DUT hookup
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          operation = '0;
    logic [31:0]         now_ms = '0;
    logic                adc_ready = 1'b0;
    logic [13:0]         sample_mv = '0;

    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                charge_enable;
    logic                divider_enable;
    logic [13:0]         battery_mv;
    logic [1:0]          phase;

    backup_battery_charge_sequencer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .now_ms         (now_ms),
        .adc_ready      (adc_ready),
        .sample_mv      (sample_mv),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .charge_enable  (charge_enable),
        .divider_enable (divider_enable),
        .battery_mv     (battery_mv),
        .phase          (phase)
    );

    // ------------------------------------------------------------------
    // Shadow of the sequencer: register copy plus all internal state
    // ------------------------------------------------------------------
    cfg_t        cfg;
    logic [1:0]  st_phase;
    logic [31:0] st_anchor;
    logic [31:0] st_charge_mark;
    logic [31:0] st_settle_mark;
    logic        st_due;
    logic        st_after_charge;
    logic [13:0] st_latched;
    logic        st_charge_on;
    logic        st_divider_on;

    request_t    request_q[$];
    result_t     status_q[$];
    request_t    cur_req;
    logic [31:0] now_cursor;
    bit          idle_on = 1'b1;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          errors = 0;
    int          cycle_count = 0;

    // Advance the shadow sequencer by one request; returns the status that
    // the block must report afterwards.
    function automatic result_t predict_status(request_t r);
        logic [31:0] since;
        result_t     res;
        case (r.op)
            OP_TICK:
            begin
                case (st_phase)
                    PH_IDLE:
                    begin
                        // due either by flag or by wrapping period check
                        since = r.now - st_anchor;
                        if ((st_due || since >= 32'(cfg.period_ms)) && r.rdy)
                        begin
                            st_anchor = r.now;
                            st_due = 1'b0;
                            st_after_charge = 1'b0;
                            st_divider_on = 1'b1;
                            st_settle_mark = r.now;
                            st_phase = PH_MEAS;
                        end
                    end
                    PH_MEAS:
                    begin
                        since = r.now - st_settle_mark;
                        if (since >= 32'(cfg.settle_ms))
                        begin
                            st_latched = r.mv;
                            st_divider_on = 1'b0;
                            // a confirming reading never restarts charging
                            if (st_latched < cfg.threshold_mv && !st_after_charge)
                            begin
                                st_charge_on = 1'b1;
                                st_charge_mark = r.now;
                                st_phase = PH_CHRG;
                            end
                            else
                            begin
                                st_phase = PH_IDLE;
                            end
                        end
                    end
                    PH_CHRG:
                    begin
                        since = r.now - st_charge_mark;
                        if (since >= 32'(cfg.charge_ms))
                        begin
                            st_charge_on = 1'b0;
                            st_charge_mark = r.now;
                            st_phase = PH_RELAX;
                        end
                    end
                    default:
                    begin
                        // relax: period anchor stays put
                        since = r.now - st_charge_mark;
                        if (since >= 32'(cfg.rest_ms))
                        begin
                            st_after_charge = 1'b1;
                            if (r.rdy)
                            begin
                                st_divider_on = 1'b1;
                                st_settle_mark = r.now;
                                st_phase = PH_MEAS;
                            end
                        end
                    end
                endcase
            end
            OP_FORCE:
            begin
                // divider deliberately left as is
                st_charge_on = 1'b0;
                st_due = 1'b1;
                st_phase = PH_IDLE;
            end
            OP_RESTART:
            begin
                st_charge_on = 1'b1;
                st_charge_mark = r.now;
                st_phase = PH_CHRG;
            end
            default:
            begin
            end
        endcase
        res.charge_enable = st_charge_on;
        res.divider_enable = st_divider_on;
        res.battery_mv = st_latched;
        res.phase = st_phase;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: feeds request_q into the block, predicts on accept
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                status_q.push_back(predict_status(cur_req));
            // load a new request only when the slot is empty or just taken
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    cur_req = request_q.pop_front();
                    operation <= cur_req.op;
                    now_ms <= cur_req.now;
                    adc_ready <= cur_req.rdy;
                    sample_mv <= cur_req.mv;
                    in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 10);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Status monitor: checks each accepted result against the oldest
    // prediction, and throws random stall bursts at the block
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [13:0] want,
                               input logic [13:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual phase %0d",
                             $time, phase);
                    errors++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("charge_enable", 14'(want.charge_enable), 14'(charge_enable));
                    check_field("divider_enable", 14'(want.divider_enable),
                                14'(divider_enable));
                    check_field("battery_mv", want.battery_mv, battery_mv);
                    check_field("phase", 14'(want.phase), 14'(phase));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 11) == 0)
            begin
                recv_gap = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // APB write: setup phase, then access phase; pready is tied high.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // bits above each register's width are dropped
        case (idx)
            REG_THRESHOLD: cfg.threshold_mv = value[13:0];
            REG_PERIOD:    cfg.period_ms = value[30:0];
            REG_SETTLE:    cfg.settle_ms = value[15:0];
            REG_CHARGE:    cfg.charge_ms = value[30:0];
            REG_REST:      cfg.rest_ms = value[30:0];
            default:
            begin
            end
        endcase
    endtask

    // Program all five registers, with junk above each field's width.
    task automatic load_settings(input logic [31:0] thr, input logic [31:0] per,
                                 input logic [31:0] stl, input logic [31:0] chg,
                                 input logic [31:0] rst);
        write_register(REG_THRESHOLD, ($urandom << 14) | thr);
        write_register(REG_PERIOD, ($urandom << 31) | per);
        write_register(REG_SETTLE, ($urandom << 16) | stl);
        write_register(REG_CHARGE, ($urandom << 31) | chg);
        write_register(REG_REST, ($urandom << 31) | rst);
    endtask

    task automatic push_req(input logic [1:0] op, input logic [31:0] now,
                            input logic rdy, input logic [13:0] mv);
        request_t r;
        r.op = op;
        r.now = now;
        r.rdy = rdy;
        r.mv = mv;
        request_q.push_back(r);
    endtask

    // Well-formed traffic: mostly ticks with time moving forward, a few
    // huge jumps to exercise wrapping differences.
    function automatic request_t random_request();
        request_t r;
        int       pick;
        int       mv;
        pick = $urandom_range(0, 99);
        if (pick < 82)
            r.op = OP_TICK;
        else if (pick < 88)
            r.op = OP_FORCE;
        else if (pick < 94)
            r.op = OP_RESTART;
        else
            r.op = OP_IGNORED;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            now_cursor += $urandom_range(0, 40);
        else if (pick < 88)
            now_cursor += $urandom_range(41, 600);
        else if (pick < 96)
            now_cursor += $urandom;
        r.now = now_cursor;
        r.rdy = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 1))
        begin
            // hover around the threshold to hit both sides of the compare
            mv = int'(cfg.threshold_mv) + int'($urandom_range(0, 16)) - 8;
            if (mv < 0)
                mv = 0;
            if (mv > 16383)
                mv = 16383;
            r.mv = 14'(mv);
        end
        else
        begin
            r.mv = 14'($urandom_range(0, 16383));
        end
        return r;
    endfunction

    // Block is quiet once nothing is queued, driven or owed. Sampled on the
    // falling edge so all driver and monitor updates have settled.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || status_q.size() != 0);
        // result path is two registers deep; idle past it before the next step
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        cfg.threshold_mv = THRESHOLD_RST;
        cfg.period_ms = PERIOD_RST;
        cfg.settle_ms = SETTLE_RST;
        cfg.charge_ms = CHARGE_RST;
        cfg.rest_ms = REST_RST;
        st_phase = PH_IDLE;
        st_anchor = '0;
        st_charge_mark = '0;
        st_settle_mark = '0;
        st_due = 1'b1;
        st_after_charge = 1'b0;
        st_latched = '0;
        st_charge_on = 1'b0;
        st_divider_on = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walk at reset settings
        push_req(OP_IGNORED, 32'd0, 1'b0, 14'd0);            // ignored code
        push_req(OP_TICK, 32'd0, 1'b0, 14'd0);               // converter busy
        push_req(OP_TICK, 32'd5, 1'b1, 14'd0);               // due after reset
        push_req(OP_TICK, 32'd50, 1'b1, 14'd0);              // still settling
        push_req(OP_TICK, 32'd105, 1'b1, 14'h3FFF);          // high reading
        push_req(OP_FORCE, 32'd200, 1'b0, 14'd0);
        push_req(OP_TICK, 32'd201, 1'b1, 14'd0);
        push_req(OP_TICK, 32'd301, 1'b1, 14'd0);             // low, charge
        push_req(OP_TICK, 32'd7200300, 1'b1, 14'd0);         // one short
        push_req(OP_TICK, 32'd7200301, 1'b1, 14'd0);         // to relax
        push_req(OP_TICK, 32'd7500301, 1'b0, 14'd0);         // rest done, busy
        push_req(OP_TICK, 32'd7500302, 1'b1, 14'd0);         // confirm starts
        push_req(OP_TICK, 32'd7500402, 1'b1, 14'd0);         // low, no recharge
        push_req(OP_TICK, 32'd7500500, 1'b1, 14'd0);         // period not up
        push_req(OP_RESTART, 32'd7500600, 1'b0, 14'd0);
        push_req(OP_FORCE, 32'd7500700, 1'b0, 14'd0);        // stops charging
        push_req(OP_TICK, 32'hFFFF_FFF0, 1'b1, 14'd0);
        push_req(OP_TICK, 32'h0000_0060, 1'b1, 14'd2849);    // across the wrap
        push_req(OP_RESTART, 32'hFFFF_FFFF, 1'b1, 14'h3FFF);
        push_req(OP_IGNORED, 32'hFFFF_FFFF, 1'b1, 14'h3FFF);
        push_req(OP_FORCE, 32'h0000_0100, 1'b1, 14'd0);
        push_req(OP_TICK, 32'h0000_0101, 1'b1, 14'd0);       // divider on
        push_req(OP_FORCE, 32'h0000_0102, 1'b1, 14'd0);      // divider kept on
        push_req(OP_TICK, 32'h0000_0103, 1'b1, 14'd0);
        push_req(OP_TICK, 32'h0000_0167, 1'b1, 14'd3000);
        wait_drained();

        // start just short of the wrap so early phases cross it
        now_cursor = 32'hFFFF_FE00;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1:       load_settings(0, 0, 0, 0, 0);       // all minimal
                3:       load_settings(16383, 32'h7FFF_FFFF, 65535,
                                       32'h7FFF_FFFF, 32'h7FFF_FFFF);
                default: load_settings($urandom_range(0, 16383), $urandom_range(1, 400),
                                       $urandom_range(0, 30), $urandom_range(1, 200),
                                       $urandom_range(0, 100));
            endcase
            // last phase runs back to back with no idling on either side
            if (ph == NUM_PHASES - 1)
                idle_on = 1'b0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // sender holds off mid-phase until every result is back
                if (ph == 2 && n == RANDOM_PER_PHASE / 2)
                    wait_drained();
                request_q.push_back(random_request());
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
